FILE: hdl/dm1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dm1_pkg
// Shared types and constants of the diagnostic trouble code parser.
// ----------------------------------------------------------------------------
package dm1_pkg;

  // record kinds
  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // field widths and constants
  localparam int unsigned SPN_W = 19;
  localparam int unsigned FMI_W = 5;
  localparam int unsigned OC_W  = 7;
  localparam logic [SPN_W-1:0] SPN_PAD = 19'h7FFFF;
  localparam logic [FMI_W-1:0] FMI_ALL = 5'h1F;

  // byte position inside a message, one-hot
  typedef enum logic [5:0] {
    PH_LAMP = 6'b000001,
    PH_SKIP = 6'b000010,
    PH_G0   = 6'b000100,
    PH_G1   = 6'b001000,
    PH_G2   = 6'b010000,
    PH_G3   = 6'b100000
  } phase_e;

  // one result record
  typedef struct packed {
    logic             record_kind;
    logic [SPN_W-1:0] suspect_number;
    logic [FMI_W-1:0] failure_mode;
    logic [OC_W-1:0]  occurrences;
    logic [7:0]       lamp_bits;
    logic             last;
  } result_t;

  // records produced by one accepted byte, slot 0 first
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } push_t;

endpackage
`default_nettype wire

FILE: hdl/dm1_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dm1_in_if / dm1_out_if
// Valid/ready channels for message bytes and for result records.
// ----------------------------------------------------------------------------
interface dm1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface dm1_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [18:0] suspect_number;
  logic [4:0]  failure_mode;
  logic [6:0]  occurrences;
  logic [7:0]  lamp_bits;
  logic        last;

  modport source (output valid, output record_kind, output suspect_number,
                  output failure_mode, output occurrences, output lamp_bits,
                  output last, input ready);
  modport sink   (input valid, input record_kind, input suspect_number,
                  input failure_mode, input occurrences, input lamp_bits,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/dm1_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dm1_parse
// Byte position tracking, group assembly and record decode for one byte.
// ----------------------------------------------------------------------------
module dm1_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_message_i,
  output dm1_pkg::push_t     push_o
);

  dm1_pkg::phase_e phase_q, phase_d;
  logic [7:0]  lamp_q, lamp_d;
  logic [23:0] held_q, held_d;

  logic [18:0] spn;
  logic [4:0]  fmi;
  logic        code_ok;
  logic        code_vld;
  logic [7:0]  lamp_out;
  dm1_pkg::result_t code_rec, end_rec;

  // fields of a completed group
  assign spn = {held_q[23:21], held_q[15:8], held_q[7:0]};
  assign fmi = held_q[20:16];
  assign code_ok = !((spn == '0) && (fmi == '0)) &&
                   !((spn == dm1_pkg::SPN_PAD) && (fmi == dm1_pkg::FMI_ALL));

  // one-byte message reports lamp status zero
  assign lamp_out = (phase_q == dm1_pkg::PH_LAMP) ? 8'h00 : lamp_q;

  // next position and held bytes
  always_comb begin
    phase_d  = phase_q;
    lamp_d   = lamp_q;
    held_d   = held_q;
    code_vld = 1'b0;
    unique case (phase_q)
      dm1_pkg::PH_LAMP: begin
        lamp_d  = data_byte_i;
        phase_d = dm1_pkg::PH_SKIP;
      end
      dm1_pkg::PH_SKIP: begin
        phase_d = dm1_pkg::PH_G0;
      end
      dm1_pkg::PH_G1: begin
        held_d[15:8] = data_byte_i;
        phase_d      = dm1_pkg::PH_G2;
      end
      dm1_pkg::PH_G2: begin
        held_d[23:16] = data_byte_i;
        phase_d       = dm1_pkg::PH_G3;
      end
      dm1_pkg::PH_G3: begin
        code_vld = code_ok;
        phase_d  = dm1_pkg::PH_G0;
      end
      default: begin
        held_d  = {16'h0000, data_byte_i};
        phase_d = dm1_pkg::PH_G1;
      end
    endcase
    if (end_of_message_i) begin
      phase_d = dm1_pkg::PH_LAMP;
      lamp_d  = 8'h00;
    end
  end

  // record contents
  always_comb begin
    code_rec                = '0;
    code_rec.record_kind    = dm1_pkg::KIND_CODE;
    code_rec.suspect_number = spn;
    code_rec.failure_mode   = fmi;
    code_rec.occurrences    = data_byte_i[6:0];
    end_rec                 = '0;
    end_rec.record_kind     = dm1_pkg::KIND_END;
    end_rec.lamp_bits       = lamp_out;
    end_rec.last            = 1'b1;
  end

  // records handed to the queue for this byte
  always_comb begin
    push_o.slot0 = code_vld ? code_rec : end_rec;
    push_o.slot1 = end_rec;
    push_o.count = 2'b00;
    if (take_i) begin
      push_o.count = {1'b0, code_vld} + {1'b0, end_of_message_i};
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dm1_pkg::PH_LAMP;
      lamp_q  <= 8'h00;
    end else if (take_i) begin
      phase_q <= phase_d;
      lamp_q  <= lamp_d;
    end
  end

  // group bytes, always written before they are read
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dm1_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dm1_queue
// Four-entry result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module dm1_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dm1_pkg::push_t    push_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output dm1_pkg::result_t       data_o
);

  dm1_pkg::result_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign space_o = (cnt_q <= 3'd2);
  assign pop     = valid_o && ready_i;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q + push_i.count;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.slot0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.slot1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dm1_trouble_code_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dm1_trouble_code_parser
// Splits a diagnostic message byte stream into trouble code and end records.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle while in_i.ready is high. Each
// byte is decoded in the cycle it is accepted and its records (none, one or
// two) are written into a four-entry result queue, from which they reach the
// output in order. The queue drains one record per cycle while out_o.ready
// is high; in_i.ready is low only while fewer than two entries are free, which
// at a steady output rate of one record per cycle never happens, so the
// sustained rate is one byte per cycle. A byte that yields both a code and an
// end record writes both into the queue together.
module dm1_trouble_code_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dm1_in_if.sink    in_i,
  dm1_out_if.source out_o
);

  logic             take;
  logic             space;
  dm1_pkg::push_t   push;
  dm1_pkg::result_t head;

  assign in_i.ready = space;
  assign take       = in_i.valid && space;

  // byte decode and message state
  dm1_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .data_byte_i      (in_i.data_byte),
    .end_of_message_i (in_i.end_of_message),
    .push_o           (push)
  );

  // result queue
  dm1_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  // output payload
  assign out_o.record_kind    = head.record_kind;
  assign out_o.suspect_number = head.suspect_number;
  assign out_o.failure_mode   = head.failure_mode;
  assign out_o.occurrences    = head.occurrences;
  assign out_o.lamp_bits      = head.lamp_bits;
  assign out_o.last           = head.last;

endmodule
`default_nettype wire

FILE: tb/dm1_trouble_code_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dm1_trouble_code_parser_test
// Drives diagnostic message byte streams into the trouble code parser and
// checks every output record against a cycle-free decoder of the same format.
// Covers short and truncated messages, dropped no-fault and padding codes,
// random messages with sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module dm1_trouble_code_parser_test;
  import dm1_pkg::*;

  // receiver behavior
  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;

  logic clk_i = 1'b0;
  logic rst_ni;

  dm1_in_if  msg_if ();
  dm1_out_if rec_if ();

  dm1_trouble_code_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (msg_if),
    .out_o  (rec_if)
  );

  // decoder state, mirrors the byte position inside a message
  phase_e      dec_phase;
  logic [7:0]  dec_lamp;
  logic [23:0] dec_held;

  result_t     pending_records[$];
  logic [7:0]  msg_bytes[$];
  int          error_count  = 0;
  int          bytes_sent   = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b0;
  int          stall_mode   = STALL_NONE;
  int          hold_request = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decode one accepted byte and queue the records it produces
  function automatic void decode_byte(input logic [7:0] b, input logic eom);
    result_t          rec;
    logic [7:0]       lamp_out;
    logic [SPN_W-1:0] spn;
    logic [FMI_W-1:0] fmi;
    // a one-byte message reports no lamp status
    lamp_out = (dec_phase == PH_LAMP) ? 8'h00 : dec_lamp;
    case (dec_phase)
      PH_LAMP: begin
        dec_lamp  = b;
        dec_phase = PH_SKIP;
      end
      PH_SKIP: dec_phase = PH_G0;
      PH_G0: begin
        dec_held  = {16'h0000, b};
        dec_phase = PH_G1;
      end
      PH_G1: begin
        dec_held[15:8] = b;
        dec_phase      = PH_G2;
      end
      PH_G2: begin
        dec_held[23:16] = b;
        dec_phase       = PH_G3;
      end
      default: begin
        // fourth byte completes the code, occurrence top bit ignored
        spn = {dec_held[23:21], dec_held[15:0]};
        fmi = dec_held[20:16];
        if (!((spn == '0 && fmi == '0) || (spn == SPN_PAD && fmi == FMI_ALL))) begin
          rec                = '0;
          rec.record_kind    = KIND_CODE;
          rec.suspect_number = spn;
          rec.failure_mode   = fmi;
          rec.occurrences    = b[6:0];
          pending_records    = {pending_records, rec};
        end
        dec_held  = '0;
        dec_phase = PH_G0;
      end
    endcase
    // end record, trailing partial group is dropped
    if (eom) begin
      rec             = '0;
      rec.record_kind = KIND_END;
      rec.lamp_bits   = lamp_out;
      rec.last        = 1'b1;
      pending_records = {pending_records, rec};
      dec_phase = PH_LAMP;
      dec_lamp  = '0;
      dec_held  = '0;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare each accepted record with the oldest expectation
  always @(posedge clk_i) begin : record_checker
    result_t exp_rec;
    if (rst_ni && rec_if.valid && rec_if.ready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %0b spn 0x%0h lamp 0x%0h",
                 $time, rec_if.record_kind, rec_if.suspect_number, rec_if.lamp_bits);
        error_count++;
      end else begin
        exp_rec = pending_records.pop_front();
        check_field("record_kind", exp_rec.record_kind, rec_if.record_kind);
        check_field("suspect_number", exp_rec.suspect_number, rec_if.suspect_number);
        check_field("failure_mode", exp_rec.failure_mode, rec_if.failure_mode);
        check_field("occurrences", exp_rec.occurrences, rec_if.occurrences);
        check_field("lamp_bits", exp_rec.lamp_bits, rec_if.lamp_bits);
        check_field("last", exp_rec.last, rec_if.last);
      end
    end
  end

  // output ready, with stall patterns and long hold-offs on request
  initial begin : receiver
    int   hold_left;
    int   tick;
    logic rdy;
    hold_left    = 0;
    tick         = 0;
    rec_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_RANDOM:  rdy = ($urandom_range(0, 99) >= 40);
          STALL_PATTERN: rdy = ((tick % 11) >= 4);
          default:       rdy = 1'b1;
        endcase
      end
      rec_if.ready <= rdy;
    end
  end

  // one byte request, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk_i);
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= b;
    msg_if.end_of_message <= eom;
    do @(posedge clk_i); while (!msg_if.ready);
    decode_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      msg_if.valid <= 1'b0;
    end
  endtask

  // bursts of random length with optional gaps between them
  task automatic send_paced(input logic [7:0] b, input logic eom);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) idle_cycles($urandom_range(1, 8));
    end
    burst_left--;
    send_byte(b, eom);
  endtask

  task automatic send_queued();
    foreach (msg_bytes[i]) send_paced(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // one four-byte code group, biased toward the dropped and edge cases
  task automatic append_group();
    logic [7:0] oc_byte;
    oc_byte = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: msg_bytes = {msg_bytes, 8'h00, 8'h00, 8'h00, oc_byte};
      1: msg_bytes = {msg_bytes, 8'hFF, 8'hFF, 8'hFF, oc_byte};
      2: msg_bytes = {msg_bytes, 8'hFF, 8'hFF, {3'b111, 5'($urandom_range(0, 30))}, oc_byte};
      3: msg_bytes = {msg_bytes, 8'h00, 8'h00, {3'b000, 5'($urandom_range(1, 31))}, oc_byte};
      4: msg_bytes = {msg_bytes, 8'h00, 8'h00, {3'($urandom_range(1, 7)), 5'b00000}, oc_byte};
      default: begin
        msg_bytes = {msg_bytes, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), oc_byte};
      end
    endcase
  endtask

  // well-formed message or a random-length noise message
  task automatic send_message(input bit noisy, input int max_groups);
    int n;
    msg_bytes.delete();
    if (noisy) begin
      n = $urandom_range(1, 12);
      repeat (n) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
    end else begin
      msg_bytes = {msg_bytes, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      n = $urandom_range(0, max_groups);
      repeat (n) append_group();
      // truncated trailing group now and then
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
      end
    end
    send_queued();
  endtask

  task automatic test_directed();
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b0;
    // single byte message, lamp not reported
    msg_bytes = {8'hA5};
    send_queued();
    // lamp and skipped byte only
    msg_bytes = {8'hFF, 8'h00};
    send_queued();
    // code and end record from the same byte, occurrence top bit set
    msg_bytes = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hE0, 8'hFF};
    send_queued();
    // no-fault code, padding code, kept code, truncated group
    msg_bytes = {8'h5A, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80,
                 8'h00, 8'h00, 8'h01, 8'h00, 8'h12, 8'h34};
    send_queued();
  endtask

  task automatic test_random_messages();
    int msg_count;
    msg_count = 0;
    while (bytes_sent < 790) begin
      // change the pacing every few messages
      if (msg_count % 6 == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_PATTERN);
        gaps_on    = $urandom_range(0, 2) != 0;
      end
      send_message($urandom_range(0, 99) < 15, ($urandom_range(0, 9) == 0) ? 8 : 4);
      msg_count++;
    end
  endtask

  // receiver holds off while the sender keeps the input busy
  task automatic test_backpressure();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    idle_cycles(1);
    hold_request = 120;
    repeat (5) send_message(1'b0, 3);
  endtask

  initial begin : main
    int waited;
    rst_ni                = 1'b0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'h00;
    msg_if.end_of_message = 1'b0;
    dec_phase             = PH_LAMP;
    dec_lamp              = '0;
    dec_held              = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_messages();
    test_backpressure();

    // drain the remaining records
    idle_cycles(1);
    stall_mode = STALL_NONE;
    waited     = 0;
    while (pending_records.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_records.size() != 0)
      $display("%0t: %0d expected records never arrived", $time, pending_records.size());
    if (error_count == 0 && pending_records.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("%0t: run limit reached", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hdl/dm1_pkg.sv
hdl/dm1_if.sv
hdl/dm1_parse.sv
hdl/dm1_queue.sv
hdl/dm1_trouble_code_parser.sv
tb/dm1_trouble_code_parser_test.sv
